### hw/rtl/lude_pkg.sv
// Package for the LU decomposition engine: widths, sizes and the fixed-point helpers.
// No dependencies.
package lude_pkg;
   localparam int MaxSizeDefault = 8;
   localparam int ValueWidth = 32;
   localparam int SizeWidth = 4;
   localparam int IndexWidth = 3;
   localparam int QShift = 16;

   typedef logic signed [ValueWidth-1:0] value_type;

   // Saturate a signed 64-bit value into the signed 32-bit range.
   function automatic value_type sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[ValueWidth-1:0];
      end
   endfunction
endpackage

### hw/rtl/lude_if.sv
// Valid/ready channel interfaces for the LU decomposition engine.
// No dependencies.
interface lude_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] element_value;
   modport source (output valid, output element_value, input ready);
   modport sink (input valid, input element_value, output ready);
endinterface

interface lude_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] factor_value;
   logic [2:0] row_index;
   logic [2:0] col_index;
   logic singular;
   logic last_of_run;
   modport source (output valid, output factor_value, output row_index, output col_index,
                   output singular, output last_of_run, input ready);
   modport sink (input valid, input factor_value, input row_index, input col_index,
                 input singular, input last_of_run, output ready);
endinterface

interface lude_csr_if;
   logic valid;
   logic ready;
   logic [3:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lude_divider.sv
// Restoring divider for Q16.16 quotients: (a * 2^16) / b, truncating, saturated.
// Depends on lude_pkg. One quotient bit per cycle.
module lude_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [31:0] numer,
   input  logic signed [31:0] denom,
   output logic done,
   output logic signed [31:0] quotient
);
   import lude_pkg::*;

   typedef enum logic [1:0] {IDLE, RUN, FIN} state_type;
   state_type state_ff;
   logic [47:0] dvd_ff;
   logic [47:0] quo_ff;
   logic [32:0] rem_ff;
   logic [31:0] dsr_ff;
   logic neg_ff;
   logic [5:0] cnt_ff;
   logic done_ff;
   value_type quot_ff;

   logic [32:0] shl_in;
   logic signed [63:0] sq_in;

   assign shl_in = {rem_ff[31:0], dvd_ff[47]};
   assign sq_in = neg_ff ? -$signed({16'd0, quo_ff}) : $signed({16'd0, quo_ff});

   // Sequence one division.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  dvd_ff <= {(numer[31] ? 32'(-numer) : 32'(numer)), 16'd0};
                  dsr_ff <= denom[31] ? 32'(-denom) : 32'(denom);
                  neg_ff <= numer[31] ^ denom[31];
                  rem_ff <= '0;
                  quo_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= RUN;
               end
            end
            RUN: begin
               dvd_ff <= {dvd_ff[46:0], 1'b0};
               if (shl_in >= {1'b0, dsr_ff}) begin
                  rem_ff <= shl_in - {1'b0, dsr_ff};
                  quo_ff <= {quo_ff[46:0], 1'b1};
               end else begin
                  rem_ff <= shl_in;
                  quo_ff <= {quo_ff[46:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd47) state_ff <= FIN;
            end
            FIN: begin
               quot_ff <= sat32(sq_in);
               done_ff <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quotient = quot_ff;
endmodule

### hw/rtl/lude_core.sv
// Sequencer, working memory and shared multiply-subtract unit of the LU engine.
// Depends on lude_pkg, lude_if and lude_divider.
module lude_core #(
   parameter int MAX_SIZE = lude_pkg::MaxSizeDefault
) (
   input logic clock,
   input logic reset,
   lude_req_if.sink req,
   lude_rsp_if.source rsp,
   lude_csr_if.sink csr
);
   import lude_pkg::*;

   localparam int Depth = MAX_SIZE * MAX_SIZE;
   localparam int AW = $clog2(Depth);
   localparam int CW = $clog2(Depth + 1);
   localparam int IW = $clog2(MAX_SIZE + 1);

   typedef enum logic [3:0] {
      LOAD, PIV_RD, PIV_CHK, DIV_RD, DIV_GO, DIV_WAIT, UPD_RD_L, UPD_RD_U,
      UPD_RD_A, UPD_MUL, UPD_WR, OUT_RD, OUT_HOLD, OUT_SING
   } state_type;

   state_type state_ff;
   value_type mem [Depth];
   value_type rd_ff;
   logic [AW-1:0] rd_addr_in;
   logic rd_en_in;
   logic [AW-1:0] wr_addr_in;
   value_type wr_data_in;
   logic wr_en_in;

   logic [SizeWidth-1:0] size_ff;
   logic [CW-1:0] load_ff;
   logic [IW-1:0] n_in;
   logic [IW-1:0] k_ff, i_ff, j_ff;
   value_type piv_ff, l_ff, u_ff, a_ff;
   logic signed [63:0] prod_ff;
   logic div_start_in, div_done;
   value_type div_q;

   logic rsp_valid_ff, rsp_sing_ff, rsp_last_ff;
   value_type rsp_val_ff;
   logic [IndexWidth-1:0] rsp_row_ff, rsp_col_ff;

   // Clamp the configured size.
   always_comb begin
      if (size_ff == '0) n_in = IW'(1);
      else if (32'(size_ff) > MAX_SIZE) n_in = IW'(MAX_SIZE);
      else n_in = IW'(size_ff);
   end

   function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                          input logic [IW-1:0] n);
      logic [2*IW-1:0] t;
      t = r * n + {{IW{1'b0}}, c};
      addr = t[AW-1:0];
   endfunction

   logic signed [63:0] prod_sh;
   logic signed [63:0] diff;
   value_type mul_res;
   logic [CW-1:0] total;
   assign total = CW'(n_in * n_in);
   assign prod_sh = prod_ff / 64'sd65536;
   assign mul_res = sat32(prod_sh);
   assign diff = 64'(a_ff) - 64'(mul_res);

   lude_divider u_div (
      .clock(clock), .reset(reset), .start(div_start_in), .numer(rd_ff), .denom(piv_ff),
      .done(div_done), .quotient(div_q)
   );

   assign req.ready = (state_ff == LOAD) && !csr.valid;
   assign csr.ready = (state_ff == LOAD);
   assign div_start_in = (state_ff == DIV_GO);

   // Memory address and write selection.
   always_comb begin
      rd_en_in = 1'b1;
      wr_en_in = 1'b0;
      wr_addr_in = addr(i_ff, j_ff, n_in);
      wr_data_in = sat32(diff);
      rd_addr_in = addr(i_ff, j_ff, n_in);
      unique case (state_ff)
         LOAD: begin
            wr_en_in = req.valid && req.ready;
            wr_addr_in = load_ff[AW-1:0];
            wr_data_in = req.element_value;
         end
         PIV_RD: rd_addr_in = addr(k_ff, k_ff, n_in);
         DIV_RD: rd_addr_in = addr(i_ff, k_ff, n_in);
         DIV_WAIT: begin
            wr_en_in = div_done;
            wr_addr_in = addr(i_ff, k_ff, n_in);
            wr_data_in = div_q;
         end
         UPD_RD_L: rd_addr_in = addr(i_ff, k_ff, n_in);
         UPD_RD_U: rd_addr_in = addr(k_ff, j_ff, n_in);
         UPD_WR: wr_en_in = 1'b1;
         default: ;
      endcase
   end

   // Hold the working matrix.
   always_ff @(posedge clock) begin
      if (wr_en_in) mem[wr_addr_in] <= wr_data_in;
      if (rd_en_in) rd_ff <= mem[rd_addr_in];
   end

   // Sequence load, factorisation and output.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
         size_ff <= SizeWidth'(8);
         load_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            size_ff <= csr.data;
            load_ff <= '0;
         end
         unique case (state_ff)
            LOAD: begin
               if (req.valid && req.ready) begin
                  if (load_ff + CW'(1) >= total) begin
                     load_ff <= '0;
                     k_ff <= '0;
                     state_ff <= PIV_RD;
                  end else begin
                     load_ff <= load_ff + CW'(1);
                  end
               end
            end
            PIV_RD: state_ff <= PIV_CHK;
            PIV_CHK: begin
               piv_ff <= rd_ff;
               if (rd_ff == '0) begin
                  state_ff <= OUT_SING;
               end else if (k_ff + IW'(1) >= n_in) begin
                  i_ff <= '0; j_ff <= '0;
                  state_ff <= OUT_RD;
               end else begin
                  i_ff <= k_ff + IW'(1);
                  state_ff <= DIV_RD;
               end
            end
            DIV_RD: state_ff <= DIV_GO;
            DIV_GO: state_ff <= DIV_WAIT;
            DIV_WAIT: begin
               if (div_done) begin
                  if (i_ff + IW'(1) >= n_in) begin
                     i_ff <= k_ff + IW'(1);
                     j_ff <= k_ff + IW'(1);
                     state_ff <= UPD_RD_L;
                  end else begin
                     i_ff <= i_ff + IW'(1);
                     state_ff <= DIV_RD;
                  end
               end
            end
            UPD_RD_L: state_ff <= UPD_RD_U;
            UPD_RD_U: begin
               l_ff <= rd_ff;
               state_ff <= UPD_RD_A;
            end
            UPD_RD_A: begin
               u_ff <= rd_ff;
               state_ff <= UPD_MUL;
            end
            UPD_MUL: begin
               a_ff <= rd_ff;
               prod_ff <= 64'(l_ff) * 64'(u_ff);
               state_ff <= UPD_WR;
            end
            UPD_WR: begin
               if (j_ff + IW'(1) < n_in) begin
                  j_ff <= j_ff + IW'(1);
                  state_ff <= UPD_RD_L;
               end else if (i_ff + IW'(1) < n_in) begin
                  i_ff <= i_ff + IW'(1);
                  j_ff <= k_ff + IW'(1);
                  state_ff <= UPD_RD_L;
               end else begin
                  k_ff <= k_ff + IW'(1);
                  state_ff <= PIV_RD;
               end
            end
            OUT_RD: state_ff <= OUT_HOLD;
            OUT_HOLD: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_val_ff <= rd_ff;
                  rsp_row_ff <= IndexWidth'(i_ff);
                  rsp_col_ff <= IndexWidth'(j_ff);
                  rsp_sing_ff <= 1'b0;
                  rsp_last_ff <= (i_ff + IW'(1) == n_in) && (j_ff + IW'(1) == n_in);
               end else if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= LOAD;
                  end else begin
                     if (j_ff + IW'(1) < n_in) j_ff <= j_ff + IW'(1);
                     else begin
                        j_ff <= '0;
                        i_ff <= i_ff + IW'(1);
                     end
                     state_ff <= OUT_RD;
                  end
               end
            end
            OUT_SING: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_val_ff <= '0;
                  rsp_row_ff <= '0;
                  rsp_col_ff <= '0;
                  rsp_sing_ff <= 1'b1;
                  rsp_last_ff <= 1'b1;
               end else if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= LOAD;
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.factor_value = rsp_val_ff;
   assign rsp.row_index = rsp_row_ff;
   assign rsp.col_index = rsp_col_ff;
   assign rsp.singular = rsp_sing_ff;
   assign rsp.last_of_run = rsp_last_ff;
endmodule

### hw/rtl/lu_decomposition_engine.sv
// Top level of the LU decomposition engine (Doolittle, no pivoting, Q16.16).
// Depends on lude_pkg, lude_if and lude_core.
//
// Usage:
//   csr_*  : write matrix_size (1..8, 0 taken as 1, above MAX_SIZE clamped); also
//            discards any partly loaded matrix. Ready only while loading.
//   req_*  : one element per beat, row-major. Ready while loading only.
//   rsp_*  : n*n beats, row-major, L below the diagonal and U on/above it, or one
//            beat with singular set when a pivot is zero.
// Factorisation uses one shared divider (L elements, n*(n-1)/2 of them) and one
//   shared multiply-subtract unit (Schur updates, (n-1)n(2n-1)/6 of them).
// Reset: size 8, load count zero, no result pending.
// Stall: a result beat holds until rsp_ready; the sequencer waits meanwhile.
module lu_decomposition_engine #(
   parameter int MAX_SIZE = lude_pkg::MaxSizeDefault
) (
   input logic clock,
   input logic reset,
   lude_req_if.sink req,
   lude_rsp_if.source rsp,
   lude_csr_if.sink csr
);
   import lude_pkg::*;

   lude_core #(.MAX_SIZE(MAX_SIZE)) u_core (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   // A result never coincides with loading.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && req.ready)) else $error("result beat while loading");

   // A stalled result holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.factor_value)
         && $stable(rsp.last_of_run))) else $error("result changed under stall");

   // A singular result is always the last of its run.
   a_sing_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.singular) |-> rsp.last_of_run) else $error("singular not last");
endmodule

### test/tb_lude_if.sv
// Testbench-side note: the channel interfaces come from the RTL (lude_if.sv).
// This file holds the scoreboard class used by tb_top; depends on lude_pkg.
package tb_lude_sb_pkg;
   import lude_pkg::*;

   typedef struct packed {
      logic signed [31:0] factor_value;
      logic [2:0] row_index;
      logic [2:0] col_index;
      logic singular;
      logic last_of_run;
   } factor_beat_type;

   class lu_scoreboard;
      logic signed [31:0] work [64];
      int unsigned load_count;
      logic [3:0] size_reg;
      factor_beat_type pending_factors[$];
      int fail_count;

      function new();
         load_count = 0;
         size_reg = 4'd8;
         fail_count = 0;
      endfunction

      function int unsigned dim();
         int unsigned n;
         n = size_reg;
         if (n == 0) n = 1;
         if (n > 8) n = 8;
         return n;
      endfunction

      function void write_size(logic [3:0] v);
         size_reg = v;
         load_count = 0;
      endfunction

      function logic signed [31:0] clamp32(logic signed [63:0] v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
         logic signed [63:0] p;
         p = 64'(a) * 64'(b);
         return clamp32(p / 64'sd65536);
      endfunction

      function logic signed [31:0] q_div(logic signed [31:0] a, logic signed [31:0] b);
         logic signed [63:0] num;
         num = 64'(a) * 64'sd65536;
         return clamp32(num / 64'(b));
      endfunction

      // Note one loaded element; on the last one, factor and queue the results.
      function void note_element(logic signed [31:0] v);
         int unsigned n, i, j, k;
         logic signed [31:0] piv, l;
         bit sing;
         factor_beat_type b;
         n = dim();
         sing = 0;
         if (load_count >= n * n) load_count = 0;
         work[load_count] = v;
         load_count++;
         if (load_count < n * n) return;
         load_count = 0;
         for (k = 0; k < n && !sing; k++) begin
            piv = work[k*n+k];
            if (piv == 0) begin
               sing = 1;
               break;
            end
            for (i = k + 1; i < n; i++) work[i*n+k] = q_div(work[i*n+k], piv);
            for (i = k + 1; i < n; i++) begin
               l = work[i*n+k];
               for (j = k + 1; j < n; j++)
                  work[i*n+j] = clamp32(64'(work[i*n+j]) - 64'(q_mul(l, work[k*n+j])));
            end
         end
         if (sing) begin
            b = '{factor_value: 0, row_index: 0, col_index: 0, singular: 1, last_of_run: 1};
            pending_factors.push_back(b);
            return;
         end
         for (i = 0; i < n; i++)
            for (j = 0; j < n; j++) begin
               b.factor_value = work[i*n+j];
               b.row_index = i[2:0];
               b.col_index = j[2:0];
               b.singular = 0;
               b.last_of_run = (i == n - 1 && j == n - 1);
               pending_factors.push_back(b);
            end
      endfunction

      // Check one result beat against the oldest queued factor.
      function void check_factor(factor_beat_type got);
         factor_beat_type exp_b;
         if (pending_factors.size() == 0) begin
            $error("unexpected result beat: value %0d row %0d col %0d",
                   got.factor_value, got.row_index, got.col_index);
            fail_count++;
            return;
         end
         exp_b = pending_factors.pop_front();
         if (got.factor_value !== exp_b.factor_value) begin
            $error("factor_value: expected %0d, got %0d", exp_b.factor_value, got.factor_value);
            fail_count++;
         end
         if (got.row_index !== exp_b.row_index) begin
            $error("row_index: expected %0d, got %0d", exp_b.row_index, got.row_index);
            fail_count++;
         end
         if (got.col_index !== exp_b.col_index) begin
            $error("col_index: expected %0d, got %0d", exp_b.col_index, got.col_index);
            fail_count++;
         end
         if (got.singular !== exp_b.singular) begin
            $error("singular: expected %0b, got %0b", exp_b.singular, got.singular);
            fail_count++;
         end
         if (got.last_of_run !== exp_b.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", exp_b.last_of_run, got.last_of_run);
            fail_count++;
         end
      endfunction
   endclass
endpackage

### test/tb_top.sv
// Top-level testbench for lu_decomposition_engine: directed and random matrices,
// random stalls on both channels. Depends on lude_pkg, lude_if and tb_lude_sb_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tb_lude_sb_pkg::*;

   localparam int CycleLimit = 2000000;

   logic clock = 0;
   logic reset = 1;
   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;
   longint unsigned cycles = 0;
   lu_scoreboard sb = new();

   lude_req_if req ();
   lude_rsp_if rsp ();
   lude_csr_if csr ();

   lu_decomposition_engine dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      req.valid = 0;
      req.element_value = 0;
      rsp.ready = 0;
      csr.valid = 0;
      csr.data = 0;
   end

   // Receiver: stall at random, check each accepted beat.
   always @(posedge clock) begin
      factor_beat_type got;
      cycles <= cycles + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.factor_value, rsp.row_index, rsp.col_index, rsp.singular,
                 rsp.last_of_run};
         sb.check_factor(got);
      end
      rsp.ready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // Abort on a hung run.
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Drive one element; valid is dropped only while idling or by the caller.
   task automatic send_element(logic signed [31:0] v);
      if ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req.valid <= 1;
      req.element_value <= v;
      do @(posedge clock); while (!req.ready);
      sb.note_element(v);
   endtask

   // Let the block drain, then write the size.
   task automatic write_size(logic [3:0] v);
      req.valid <= 0;
      while (sb.pending_factors.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      csr.valid <= 1;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      sb.write_size(v);
      csr.valid <= 0;
   endtask

   function automatic logic signed [31:0] rand_elem();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 0;
         2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed($urandom_range(8 << 16)) - (4 << 16);
      endcase
   endfunction

   // Diagonally dominant matrix, so factors stay non-singular; with wild set, random elements instead.
   task automatic send_matrix(int unsigned n, bit wild);
      for (int unsigned i = 0; i < n; i++)
         for (int unsigned j = 0; j < n; j++)
            if (wild) send_element(rand_elem());
            else if (i == j) send_element($signed($urandom_range(4 << 16)) + (9 << 16));
            else send_element($signed($urandom_range(2 << 16)) - (1 << 16));
   endtask

   initial begin
      int unsigned n;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: size extremes, clamping, zero pivots, saturating values.
      write_size(4'd1);
      send_element(32'sh7FFFFFFF);
      send_element(32'sh00000000);
      write_size(4'd0);
      send_element(32'sh80000000);
      write_size(4'd2);
      send_element(0); send_element(1 << 16); send_element(1 << 16); send_element(0);
      send_element(1 << 16); send_element(2 << 16); send_element(2 << 16); send_element(4 << 16);
      send_element(1); send_element(32'sh7FFFFFFF); send_element(32'sh80000000);
      send_element(32'sh7FFFFFFF);
      send_element(3 << 16);
      write_size(4'd15);
      send_matrix(8, 0);

      // Random: three idling phases, small sizes.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 7 : (ph == 1) ? 63 : 0;
         recv_idle = (ph == 0) ? 63 : (ph == 1) ? 7 : 0;
         for (int m = 0; m < 3; m++) begin
            n = $urandom_range(1, 3);
            write_size(n[3:0]);
            send_matrix(n, $urandom_range(3) == 0);
         end
      end
      req.valid <= 0;

      while (sb.pending_factors.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
